FILE: hw/rtl/moving_average_neighbour_alert_assert.svh
// Assertion macros shared by the moving average neighbour alert RTL.
`ifndef MOVING_AVERAGE_NEIGHBOUR_ALERT_ASSERT_SVH
`define MOVING_AVERAGE_NEIGHBOUR_ALERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MANA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MANA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/mana_pkg.sv
// Types and constants of the moving average neighbour alert block.
package mana_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int THRESHOLD_W = 16;
    localparam int BAND_W      = 12;
    localparam int MIN_W       = 3;
    localparam int COUNT_W     = 3;
    localparam int INDEX_W     = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int NBR_N       = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_THRESHOLD   = 2'd0;
    localparam t_cfg_idx CFG_BAND        = 2'd1;
    localparam t_cfg_idx CFG_MIN_MATCHES = 2'd2;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST   = 16'd6000;
    localparam logic [BAND_W-1:0]      BAND_RST        = 12'd300;
    localparam logic [MIN_W-1:0]       MIN_MATCHES_RST = 3'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] nbr_avg_top;
        logic [SAMPLE_W-1:0] nbr_avg_bottom;
        logic [SAMPLE_W-1:0] nbr_avg_left;
        logic [SAMPLE_W-1:0] nbr_avg_right;
        logic [NBR_N-1:0]    nbr_valid;
    } t_in_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                above_threshold;
        logic [COUNT_W-1:0]  match_count;
        logic                alert;
        logic [INDEX_W-1:0]  item_index;
    } t_out_rsp;

    typedef struct packed {
        logic               above;
        logic [COUNT_W-1:0] count;
        logic               alert;
    } t_nbr_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

FILE: hw/rtl/mana_div.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
module mana_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  borrow;

    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign borrow  = diff[DIVISOR_W+1];
    assign o_done  = r_busy && (r_cnt == CNT_W'(DIVIDEND_W - 1));
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ~borrow};
        end
    end

endmodule

FILE: hw/rtl/mana_nbr.sv
// Neighbour band check, match count and alert decision.
module mana_nbr (
    input  logic [mana_pkg::SAMPLE_W-1:0]    i_average,
    input  logic                             i_first,
    input  logic [mana_pkg::THRESHOLD_W-1:0] i_threshold,
    input  logic [mana_pkg::BAND_W-1:0]      i_band,
    input  logic [mana_pkg::MIN_W-1:0]       i_min_matches,
    input  mana_pkg::t_in_req                i_req,
    output mana_pkg::t_nbr_result            o_result
);
    import mana_pkg::*;

    logic [THRESHOLD_W:0]              lo_diff;
    logic                              lo_neg;
    logic [THRESHOLD_W:0]              hi;
    logic [NBR_N-1:0][SAMPLE_W-1:0]    avgs;
    logic [NBR_N-1:0]                  hit;
    logic                              above;
    logic [COUNT_W-1:0]                count;

    assign lo_diff = {1'b0, i_threshold} - (THRESHOLD_W + 1)'(i_band);
    assign lo_neg  = lo_diff[THRESHOLD_W];
    assign hi      = {1'b0, i_threshold} + (THRESHOLD_W + 1)'(i_band);
    assign avgs    = {i_req.nbr_avg_right, i_req.nbr_avg_left,
                      i_req.nbr_avg_bottom, i_req.nbr_avg_top};

    always_comb begin
        for (int k = 0; k < NBR_N; k++) begin
            hit[k] = i_req.nbr_valid[k]
                     && (lo_neg || (avgs[k] >= lo_diff[THRESHOLD_W-1:0]))
                     && ({1'b0, avgs[k]} <= hi);
        end
    end

    assign above = !i_first && (i_average > i_threshold);
    assign count = above ? COUNT_W'($countones(hit)) : '0;

    assign o_result.above = above;
    assign o_result.count = count;
    assign o_result.alert = (count >= i_min_matches);

endmodule

FILE: hw/rtl/moving_average_neighbour_alert.sv
// Boxcar moving average detector that counts neighbours near the threshold.
// A request is handled in steps: read the sample leaving the window from the ring
// memory, update the running sum, form sum / stored-sample count in the bit-serial
// divider, which gives SUM_W quotient bits with SUM_W = 16 + clog2(WINDOW), build
// the result and go back to idle. The result sits in an output register, so the
// next request is taken while a result still waits. There is no clearing pass
// after reset.
module moving_average_neighbour_alert #(
    parameter int WINDOW = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  mana_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [mana_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mana_pkg::t_in_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mana_pkg::t_out_rsp              o_out_rsp
);
    import mana_pkg::*;

    `include "moving_average_neighbour_alert_assert.svh"

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);

    t_state                  r_state, n_state;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [PTR_W-1:0]        r_wp, n_wp;
    logic [INDEX_W-1:0]      r_item_cnt;
    logic [THRESHOLD_W-1:0]  r_threshold;
    logic [BAND_W-1:0]       r_band;
    logic [MIN_W-1:0]        r_min_matches;
    logic                    r_out_valid;

    t_in_req                 r_req;
    logic                    r_first;
    logic [INDEX_W-1:0]      r_idx;
    t_out_rsp                r_out_rsp;
    logic [SAMPLE_W-1:0]     r_ring [WINDOW];
    logic [SAMPLE_W-1:0]     r_rd;

    logic                    full;
    logic                    ring_we;
    logic                    div_start;
    logic                    div_done;
    logic [SUM_W-1:0]        quotient;
    logic                    load_out;
    logic                    accept;
    t_nbr_result             nbr_res;

    assign full   = (r_fill == FILL_W'(WINDOW));
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_fill     = r_fill;
        n_wp       = r_wp;
        o_in_ready = 1'b0;
        ring_we    = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                ring_we   = 1'b1;
                div_start = 1'b1;
                if (full) begin
                    n_sum = r_sum - SUM_W'(r_rd) + SUM_W'(r_req.sample);
                end else begin
                    n_sum  = r_sum + SUM_W'(r_req.sample);
                    n_fill = r_fill + 1'b1;
                end
                n_wp    = (r_wp == PTR_W'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sum         <= '0;
            r_fill        <= '0;
            r_wp          <= '0;
            r_item_cnt    <= '0;
            r_threshold   <= THRESHOLD_RST;
            r_band        <= BAND_RST;
            r_min_matches <= MIN_MATCHES_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_fill  <= n_fill;
            r_wp    <= n_wp;
            if (accept) begin
                r_item_cnt <= r_item_cnt + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD:   r_threshold   <= i_cfg_data[THRESHOLD_W-1:0];
                    CFG_BAND:        r_band        <= i_cfg_data[BAND_W-1:0];
                    CFG_MIN_MATCHES: r_min_matches <= i_cfg_data[MIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_in_req;
            r_first <= (r_fill == '0);
            r_idx   <= r_item_cnt;
        end
        if (load_out) begin
            r_out_rsp.average         <= quotient[SAMPLE_W-1:0];
            r_out_rsp.above_threshold <= nbr_res.above;
            r_out_rsp.match_count     <= nbr_res.count;
            r_out_rsp.alert           <= nbr_res.alert;
            r_out_rsp.item_index      <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wp] <= r_req.sample;
        end
        r_rd <= r_ring[r_wp];
    end

    mana_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (FILL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    mana_nbr u_nbr (
        .i_average     (quotient[SAMPLE_W-1:0]),
        .i_first       (r_first),
        .i_threshold   (r_threshold),
        .i_band        (r_band),
        .i_min_matches (r_min_matches),
        .i_req         (r_req),
        .o_result      (nbr_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    `MANA_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n, accept, r_state == ST_READ)
    `MANA_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(WINDOW))
    `MANA_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV)
    `MANA_ASSERT_IMP(a_out_from_finish, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state == ST_FINISH))

endmodule

FILE: tb/moving_average_neighbour_alert_checker.sv
// Checker that predicts and compares every result of the moving average neighbour alert block.
module moving_average_neighbour_alert_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  mana_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [mana_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  mana_pkg::t_in_req               i_in_req,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  mana_pkg::t_out_rsp              i_out_rsp,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count,
    output int                              o_above_count,
    output int                              o_alert_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mana_pkg::*;

    localparam int WINDOW = 128;
    localparam int SUM_W  = 23;

    logic [SAMPLE_W-1:0]    sample_hist [WINDOW];
    logic [SUM_W-1:0]       sum_q;
    logic [7:0]             stored_q;
    logic [6:0]             wr_ptr_q;
    logic [INDEX_W-1:0]     index_q;
    logic [THRESHOLD_W-1:0] thr_q;
    logic [BAND_W-1:0]      band_q;
    logic [MIN_W-1:0]       min_q;
    t_out_rsp               expected_rsp_q [$];
    t_out_rsp               want;

    function automatic logic nbr_in_band(input logic [SAMPLE_W-1:0] nbr_avg);
        int lo;
        int hi;
        lo = int'(thr_q) - int'(band_q);
        hi = int'(thr_q) + int'(band_q);
        return (int'(nbr_avg) >= lo) && (int'(nbr_avg) <= hi);
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    task automatic predict_average(input t_in_req req);
        logic [SAMPLE_W-1:0] nbr [NBR_N];
        t_out_rsp            rsp;
        logic                first;
        int                  count;
        first = (stored_q == 0);
        rsp.item_index = index_q;
        if (stored_q >= WINDOW) begin
            sum_q = sum_q - sample_hist[wr_ptr_q];
        end else begin
            stored_q = stored_q + 8'd1;
        end
        sample_hist[wr_ptr_q] = req.sample;
        sum_q    = sum_q + req.sample;
        wr_ptr_q = wr_ptr_q + 7'd1;
        index_q  = index_q + 32'd1;
        rsp.average = SAMPLE_W'(sum_q / stored_q);
        rsp.above_threshold = !first && (rsp.average > thr_q);
        nbr[0] = req.nbr_avg_top;
        nbr[1] = req.nbr_avg_bottom;
        nbr[2] = req.nbr_avg_left;
        nbr[3] = req.nbr_avg_right;
        count = 0;
        if (rsp.above_threshold) begin
            for (int k = 0; k < NBR_N; k++) begin
                if (req.nbr_valid[k] && nbr_in_band(nbr[k])) begin
                    count++;
                end
            end
        end
        rsp.match_count = COUNT_W'(count);
        rsp.alert = (COUNT_W'(count) >= min_q);
        expected_rsp_q.push_back(rsp);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sum_q          = '0;
            stored_q       = '0;
            wr_ptr_q       = '0;
            index_q        = '0;
            thr_q          = THRESHOLD_RST;
            band_q         = BAND_RST;
            min_q          = MIN_MATCHES_RST;
            expected_rsp_q.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_above_count  = 0;
            o_alert_count  = 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD:   thr_q  = i_cfg_data[THRESHOLD_W-1:0];
                    CFG_BAND:        band_q = i_cfg_data[BAND_W-1:0];
                    CFG_MIN_MATCHES: min_q  = i_cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (i_out_rsp.above_threshold) o_above_count++;
                if (i_out_rsp.alert) o_alert_count++;
                if (expected_rsp_q.size() == 0) begin
                    $error("Result with no request outstanding: average %0d, index %0d",
                           i_out_rsp.average, i_out_rsp.item_index);
                    o_fail_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    o_fail_count += field_differs("average", want.average,
                                                  i_out_rsp.average);
                    o_fail_count += field_differs("above_threshold", want.above_threshold,
                                                  i_out_rsp.above_threshold);
                    o_fail_count += field_differs("match_count", want.match_count,
                                                  i_out_rsp.match_count);
                    o_fail_count += field_differs("alert", want.alert, i_out_rsp.alert);
                    o_fail_count += field_differs("item_index", want.item_index,
                                                  i_out_rsp.item_index);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_average(i_in_req);
            end
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

FILE: tb/tb_moving_average_neighbour_alert.sv
// Testbench top that drives the moving average neighbour alert block and reports the verdict.
module tb_moving_average_neighbour_alert;
    timeunit 1ns;
    timeprecision 1ps;

    import mana_pkg::*;

    localparam int       LIMIT      = 400000;
    localparam int       HOLD_OFF   = 300;
    localparam int       DRAIN_WAIT = 40;
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_idx   = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_in_req               in_req    = '0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_rsp              out_rsp;

    int fail_count;
    int pending;
    int result_count;
    int above_count;
    int alert_count;
    int cycle_count  = 0;
    int snd_idle_pct = 31;
    int rcv_idle_pct = 77;
    int stall_left   = 0;
    int cur_thr      = THRESHOLD_RST;
    int cur_band     = BAND_RST;
    int level        = 0;

    moving_average_neighbour_alert uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_rsp  (out_rsp)
    );

    moving_average_neighbour_alert_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_req      (in_req),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_rsp     (out_rsp),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_above_count (above_count),
        .o_alert_count (alert_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // A pending hold-off keeps the result side stalled while requests keep coming.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_near(input int center, input int spread);
        int v;
        v = center - spread + int'($urandom_range(2 * spread));
        if (v < 0) v = 0;
        else if (v > 65535) v = 65535;
        return SAMPLE_W'(v);
    endfunction

    function automatic t_in_req random_request();
        t_in_req             req;
        logic [SAMPLE_W-1:0] nbr [NBR_N];
        int                  kind;
        kind = $urandom_range(99);
        if (kind < 45) req.sample = pick_near(level, 3000);
        else if (kind < 65) req.sample = SAMPLE_W'($urandom);
        else if (kind < 75) req.sample = '0;
        else if (kind < 85) req.sample = '1;
        else req.sample = pick_near(cur_thr, cur_band + 50);
        for (int k = 0; k < NBR_N; k++) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                nbr[k] = pick_near(cur_thr, cur_band + 20);
            end else if (kind < 75) begin
                case ($urandom_range(3))
                    0: nbr[k] = pick_near(cur_thr - cur_band - 1, 0);
                    1: nbr[k] = pick_near(cur_thr - cur_band, 0);
                    2: nbr[k] = pick_near(cur_thr + cur_band, 0);
                    default: nbr[k] = pick_near(cur_thr + cur_band + 1, 0);
                endcase
            end else begin
                nbr[k] = SAMPLE_W'($urandom);
            end
        end
        req.nbr_avg_top    = nbr[0];
        req.nbr_avg_bottom = nbr[1];
        req.nbr_avg_left   = nbr[2];
        req.nbr_avg_right  = nbr[3];
        req.nbr_valid      = NBR_N'($urandom_range(15));
        return req;
    endfunction

    task automatic send_request(input t_in_req req);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_fields(input logic [SAMPLE_W-1:0] s, t, b, l, r,
                               input logic [NBR_N-1:0] v);
        t_in_req req;
        req.sample         = s;
        req.nbr_avg_top    = t;
        req.nbr_avg_bottom = b;
        req.nbr_avg_left   = l;
        req.nbr_avg_right  = r;
        req.nbr_valid      = v;
        send_request(req);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] thr, band, min_matches);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_BAND, band);
        write_reg(CFG_MIN_MATCHES, min_matches);
        cur_thr  = thr;
        cur_band = band[BAND_W-1:0];
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default settings: first item, band edges, each neighbour alone.
        send_fields(16'hFFFF, 16'd6000, 16'd6000, 16'd6000, 16'd6000, 4'hF);
        send_fields(16'hFFFF, 16'd5700, 16'd6300, 16'd5699, 16'd6301, 4'hF);
        send_fields(16'd0, 16'd6000, 16'd6000, 16'd6000, 16'd6000, 4'h0);
        send_fields(16'd0, 16'd6000, 16'd0, 16'd0, 16'd0, 4'h1);
        send_fields(16'd1, 16'd0, 16'd6000, 16'd0, 16'd0, 4'h2);
        send_fields(16'hFFFF, 16'd0, 16'd0, 16'd6000, 16'd0, 4'h4);
        send_fields(16'd12345, 16'd0, 16'd0, 16'd0, 16'd6000, 4'h8);
        send_fields(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_fields(16'hFFFF, 16'd6000, 16'd6000, 16'd6000, 16'd6000, 4'hF);
        wait_drained();

        // The lower edge of the band falls below zero.
        apply_config(16'd100, 16'd300, 16'd1);
        send_fields(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'hF);
        send_fields(16'd0, 16'd400, 16'd401, 16'd0, 16'hFFFF, 4'h5);
        wait_drained();

        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFC);
        send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        wait_drained();

        apply_config(16'd0, 16'd0, 16'h0008);
        send_fields(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'hF);
        send_fields(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 4'hF);
        wait_drained();

        apply_config(16'd0, 16'd4095, 16'd7);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_fields(16'hFFFF, 16'd4095, 16'd4096, 16'd0, 16'd100, 4'hF);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            snd_idle_pct = (p < 2) ? 31 : (p < 4) ? 77 : 0;
            rcv_idle_pct = (p < 2) ? 77 : (p < 4) ? 31 : 0;
            case (p)
                0: apply_config(16'd100, 16'd300, 16'd1);
                1: apply_config(16'($urandom), 16'hFFFF, 16'h0004);
                2: apply_config(16'd0, 16'd0, 16'hFFF8);
                3: apply_config(16'($urandom), 16'($urandom), 16'($urandom));
                4: apply_config(16'hFFFF, 16'($urandom), 16'h0003);
                default: apply_config(16'($urandom_range(20000, 45000)), 16'($urandom),
                                      16'h0007);
            endcase
            level = pick_near(cur_thr, 5000);
            if (p == 4) begin
                @(posedge clk);
                stall_left = HOLD_OFF;
            end
            repeat (130) send_request(random_request());
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        $display("Checked %0d results over six register settings and three idle patterns.",
                 result_count);
        $display("Averages above threshold: %0d, alerts raised: %0d.", above_count,
                 alert_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
